### rtl/core/adc_manual_scan_sequencer_assert.svh
`ifndef ADC_MANUAL_SCAN_SEQUENCER_ASSERT_SVH
`define ADC_MANUAL_SCAN_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define AMSS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("amss assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define AMSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("amss assertion failed");

`endif

### rtl/core/amss_pkg.sv
`default_nettype none

package amss_pkg;

	localparam int DEVICE_TOTAL        = 4;
	localparam int CHANNELS_PER_DEVICE = 16;
	localparam int FLUSH_FRAMES        = 2;

	localparam int DEV_W   = 2;
	localparam int CH_W    = 4;
	localparam int FRAME_W = 5;
	localparam int LIST_W  = CHANNELS_PER_DEVICE * CH_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [15:0] CMD_MANUAL   = 16'h1000;
	localparam int          CMD_CH_SHIFT = 7;

	localparam logic ACT_START    = 1'b0;
	localparam logic ACT_RESPONSE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_LIST_DEV0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_DEV0 = 3'd4;

	typedef logic [3:0][LIST_W-1:0]  list_bank_t;
	typedef logic [3:0][FRAME_W-1:0] count_bank_t;

	typedef struct packed {
		logic [DEV_W-1:0]   active_device;
		logic [FRAME_W-1:0] frame_number;
		logic               scanning;
		logic [15:0]        rejected_total;
	} scan_state_t;

	typedef struct packed {
		logic [15:0] tx_word;
		logic [1:0]  select_device;
		logic        frame_pending;
		logic        sample_valid;
		logic [5:0]  sample_index;
		logic [11:0] sample_value;
		logic        bad_channel;
		logic [15:0] bad_count;
		logic        scan_done;
	} scan_result_t;

	// Clamp a scan count to the channel count of a device.
	function automatic logic [FRAME_W-1:0] eff_count(input logic [FRAME_W-1:0] c);
		logic [FRAME_W-1:0] lim;
		lim = FRAME_W'(CHANNELS_PER_DEVICE);
		return (c > lim) ? lim : c;
	endfunction

endpackage

`default_nettype wire

### rtl/core/amss_step.sv
`default_nettype none

module amss_step (
	input  wire logic                 action,
	input  wire logic [15:0]          rx_word,
	input  wire amss_pkg::scan_state_t st,
	input  wire amss_pkg::list_bank_t  channel_list,
	input  wire amss_pkg::count_bank_t count_bank,
	output amss_pkg::scan_state_t      nxt,
	output amss_pkg::scan_result_t     res
);
	import amss_pkg::*;

	logic [LIST_W-1:0]    cur_list;
	logic [FRAME_W-1:0]   cur_eff;
	logic [15:0]          cur_mask;
	logic [CH_W-1:0]      rx_ch;
	logic [FRAME_W-1:0]   frame_inc;
	logic                 first_found;
	logic [DEV_W-1:0]     first_dev;
	logic                 later_found;
	logic [DEV_W-1:0]     later_dev;
	logic [LIST_W-1:0]    cmd_list;
	logic [FRAME_W-1:0]   cmd_eff;
	logic [CH_W-1:0]      cmd_ch;
	logic [15:0]          cmd_word;
	scan_result_t         base_res;

	assign cur_list  = channel_list[st.active_device];
	assign cur_eff   = eff_count(count_bank[st.active_device]);
	assign rx_ch     = rx_word[15:12];
	assign frame_inc = st.frame_number + FRAME_W'(1);

	// Mask of the channels the active device was told to convert.
	always_comb begin
		cur_mask = '0;
		for (int i = 0; i < CHANNELS_PER_DEVICE; i++) begin
			if (FRAME_W'(i) < cur_eff)
				cur_mask[cur_list[i*CH_W +: CH_W]] = 1'b1;
		end
	end

	// Lowest device with work, and lowest one past the active device.
	always_comb begin
		first_found = 1'b0;
		first_dev   = '0;
		later_found = 1'b0;
		later_dev   = '0;
		for (int k = DEVICE_TOTAL - 1; k >= 0; k--) begin
			if (eff_count(count_bank[k]) != '0) begin
				first_found = 1'b1;
				first_dev   = DEV_W'(k);
				if (DEV_W'(k) > st.active_device) begin
					later_found = 1'b1;
					later_dev   = DEV_W'(k);
				end
			end
		end
	end

	// Command for the frame that follows, from the updated state.
	assign cmd_list = channel_list[nxt.active_device];
	assign cmd_eff  = eff_count(count_bank[nxt.active_device]);
	assign cmd_ch   = cmd_list[nxt.frame_number[CH_W-1:0]*CH_W +: CH_W];
	assign cmd_word = (nxt.frame_number < cmd_eff)
		? (CMD_MANUAL | (16'(cmd_ch) << CMD_CH_SHIFT)) : 16'h0000;

	always_comb begin
		nxt = st;
		base_res = '0;
		case (action)
			ACT_START: begin
				nxt.frame_number = '0;
				if (first_found) begin
					nxt.active_device = first_dev;
					nxt.scanning      = 1'b1;
				end else begin
					nxt.scanning       = 1'b0;
					base_res.scan_done = 1'b1;
				end
			end
			ACT_RESPONSE: begin
				if (st.scanning) begin
					if (cur_mask[rx_ch]) begin
						base_res.sample_valid = 1'b1;
						base_res.sample_index = {st.active_device, rx_ch};
						base_res.sample_value = rx_word[11:0];
					end else begin
						base_res.bad_channel = 1'b1;
						nxt.rejected_total   = st.rejected_total + 16'd1;
					end
					nxt.frame_number = frame_inc;
					if ({1'b0, frame_inc} >=
						{1'b0, cur_eff} + (FRAME_W+1)'(FLUSH_FRAMES)) begin
						nxt.frame_number = '0;
						if (later_found) begin
							nxt.active_device = later_dev;
						end else begin
							nxt.scanning       = 1'b0;
							base_res.scan_done = 1'b1;
						end
					end
				end
			end
			default: begin
				nxt = st;
			end
		endcase
		base_res.select_device = nxt.active_device;
		base_res.bad_count     = nxt.rejected_total;
	end

	always_comb begin
		res = base_res;
		if (nxt.scanning && (action == ACT_START || st.scanning)) begin
			res.tx_word       = cmd_word;
			res.frame_pending = 1'b1;
		end
	end

endmodule

`default_nettype wire

### rtl/core/adc_manual_scan_sequencer.sv
// An accepted item goes to the input register, its result to the result register.
// Throughput: one item per cycle unless out_stall holds a full result register;
//   two stages (input, result); scan state updates in the same cycle as the decode.
// Reset (arst_n low): channel lists and scan counts clear to zero, the scan goes
//   idle at device 0 frame 0, the rejected counter clears, both stages empty.
`default_nettype none

module adc_manual_scan_sequencer (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               action,
	input  wire logic [15:0]                        rx_word,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [amss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [63:0]                        cfg_data,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [15:0]                             tx_word,
	output logic [1:0]                              select_device,
	output logic                                    frame_pending,
	output logic                                    sample_valid,
	output logic [5:0]                              sample_index,
	output logic [11:0]                             sample_value,
	output logic                                    bad_channel,
	output logic [15:0]                             bad_count,
	output logic                                    scan_done
);
	import amss_pkg::*;

	list_bank_t   channel_list_q;
	count_bank_t  count_bank_q;
	scan_state_t  st_q;
	scan_state_t  st_nxt;
	scan_result_t res_nxt;
	scan_result_t res_q;
	logic         out_valid_q;
	logic         valid_s1;
	logic         action_s1;
	logic [15:0]  rx_word_s1;
	logic         advance;
	logic         in_accept;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_list_q <= '0;
			count_bank_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index < REG_COUNT_DEV0)
				channel_list_q[cfg_index[DEV_W-1:0]] <= cfg_data;
			else
				count_bank_q[cfg_index[DEV_W-1:0]] <= cfg_data[FRAME_W-1:0];
		end
	end

	// Stage 1 moves on when the result register is empty or being taken.
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			action_s1  <= action;
			rx_word_s1 <= rx_word;
		end
	end

	amss_step u_step (
		.action       (action_s1),
		.rx_word      (rx_word_s1),
		.st           (st_q),
		.channel_list (channel_list_q),
		.count_bank   (count_bank_q),
		.nxt          (st_nxt),
		.res          (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1)
				st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			res_q <= res_nxt;
	end

	assign out_valid     = out_valid_q;
	assign tx_word       = res_q.tx_word;
	assign select_device = res_q.select_device;
	assign frame_pending = res_q.frame_pending;
	assign sample_valid  = res_q.sample_valid;
	assign sample_index  = res_q.sample_index;
	assign sample_value  = res_q.sample_value;
	assign bad_channel   = res_q.bad_channel;
	assign bad_count     = res_q.bad_count;
	assign scan_done     = res_q.scan_done;

`include "adc_manual_scan_sequencer_assert.svh"

	`AMSS_ASSERT_NOW(a_valid_not_bad, out_valid && sample_valid, !bad_channel)
	`AMSS_ASSERT_NOW(a_pending_not_done, out_valid && frame_pending, !scan_done)
	`AMSS_ASSERT_NOW(a_idle_frame_zero, !st_q.scanning, st_q.frame_number == '0)
	`AMSS_ASSERT_NEXT(a_state_holds, !(advance && valid_s1), $stable(st_q))

endmodule

`default_nettype wire

### bench/amss_scan_checker.sv
`timescale 1ns / 100ps

module amss_scan_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           action,
	input  logic [15:0]                    rx_word,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [amss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [15:0]                    tx_word,
	input  logic [1:0]                     select_device,
	input  logic                           frame_pending,
	input  logic                           sample_valid,
	input  logic [5:0]                     sample_index,
	input  logic [11:0]                    sample_value,
	input  logic                           bad_channel,
	input  logic [15:0]                    bad_count,
	input  logic                           scan_done,
	output int                             fail_count,
	output int                             due_count
);
	import amss_pkg::*;

	list_bank_t   chan_lists;
	count_bank_t  dev_limits;
	scan_state_t  scan;
	scan_result_t results_due[$];
	scan_result_t want;

	function automatic int frames_of(input int dev);
		int c;
		c = dev_limits[dev];
		return (c > CHANNELS_PER_DEVICE) ? CHANNELS_PER_DEVICE : c;
	endfunction

	function automatic logic [3:0] list_chan(input int dev, input int slot);
		return chan_lists[dev][4*slot +: 4];
	endfunction

	function automatic logic [15:0] chan_mask(input int dev);
		logic [15:0] m;
		m = '0;
		for (int i = 0; i < frames_of(dev); i++)
			m[list_chan(dev, i)] = 1'b1;
		return m;
	endfunction

	function automatic int first_live(input int from);
		for (int k = from; k < DEVICE_TOTAL; k++)
			if (frames_of(k) != 0)
				return k;
		return DEVICE_TOTAL;
	endfunction

	function automatic logic [15:0] command_for(input int dev, input int frame);
		if (frame < frames_of(dev))
			return CMD_MANUAL | (16'(list_chan(dev, frame)) << CMD_CH_SHIFT);
		return 16'h0000;
	endfunction

	// Advance the scan state by one item and return the result it yields.
	function automatic scan_result_t scan_step(input logic act, input logic [15:0] word);
		scan_result_t r;
		logic [15:0]  m;
		logic [3:0]   ch;
		int           dev;
		r = '0;
		if (act == ACT_START) begin
			dev = first_live(0);
			if (dev < DEVICE_TOTAL) begin
				scan.active_device = dev[1:0];
				scan.frame_number  = '0;
				scan.scanning      = 1'b1;
				r.tx_word          = command_for(dev, 0);
				r.frame_pending    = 1'b1;
			end else begin
				scan.scanning     = 1'b0;
				scan.frame_number = '0;
				r.scan_done       = 1'b1;
			end
		end else if (scan.scanning) begin
			ch = word[15:12];
			m  = chan_mask(scan.active_device);
			if (m[ch]) begin
				r.sample_valid = 1'b1;
				r.sample_index = {scan.active_device, ch};
				r.sample_value = word[11:0];
			end else begin
				r.bad_channel       = 1'b1;
				scan.rejected_total = scan.rejected_total + 16'd1;
			end
			scan.frame_number = scan.frame_number + 5'd1;
			if (int'(scan.frame_number) >= frames_of(scan.active_device) + FLUSH_FRAMES) begin
				dev = first_live(int'(scan.active_device) + 1);
				scan.frame_number = '0;
				if (dev < DEVICE_TOTAL) begin
					scan.active_device = dev[1:0];
				end else begin
					scan.scanning = 1'b0;
					r.scan_done   = 1'b1;
				end
			end
			if (scan.scanning) begin
				r.tx_word       = command_for(scan.active_device, scan.frame_number);
				r.frame_pending = 1'b1;
			end
		end
		r.select_device = scan.active_device;
		r.bad_count     = scan.rejected_total;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected 'h%0h, got 'h%0h", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_lists  = '0;
			dev_limits  = '0;
			scan        = '0;
			results_due.delete();
			fail_count  = 0;
			due_count  <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$error("result item with no expectation waiting");
					fail_count++;
				end else begin
					want = results_due.pop_front();
					check_field("tx_word", want.tx_word, tx_word);
					check_field("select_device", 16'(want.select_device), 16'(select_device));
					check_field("frame_pending", 16'(want.frame_pending), 16'(frame_pending));
					check_field("sample_valid", 16'(want.sample_valid), 16'(sample_valid));
					check_field("sample_index", 16'(want.sample_index), 16'(sample_index));
					check_field("sample_value", 16'(want.sample_value), 16'(sample_value));
					check_field("bad_channel", 16'(want.bad_channel), 16'(bad_channel));
					check_field("bad_count", want.bad_count, bad_count);
					check_field("scan_done", 16'(want.scan_done), 16'(scan_done));
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < REG_COUNT_DEV0)
					chan_lists[cfg_index[1:0]] = cfg_data;
				else
					dev_limits[cfg_index[1:0]] = cfg_data[FRAME_W-1:0];
			end
			if (in_valid && !in_stall)
				results_due.push_back(scan_step(action, rx_word));
			due_count <= results_due.size();
		end
	end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import amss_pkg::*;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
	typedef enum int {LIST_FULL, LIST_RANDOM, LIST_SPARSE, LIST_OVER, LIST_EMPTY} cfg_style_e;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 action;
	logic [15:0]          rx_word;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0]          cfg_data;
	logic                 out_valid;
	logic                 out_stall;
	logic [15:0]          tx_word;
	logic [1:0]           select_device;
	logic                 frame_pending;
	logic                 sample_valid;
	logic [5:0]           sample_index;
	logic [11:0]          sample_value;
	logic                 bad_channel;
	logic [15:0]          bad_count;
	logic                 scan_done;
	int                   fail_count;
	int                   due_count;

	logic [63:0] list_shadow [4];
	logic [4:0]  count_shadow [4];
	int          send_pct;
	int          stall_pct;
	int          hold_reqs;
	int          hold_seen;
	int          hold_left;
	int          items_sent;

	adc_manual_scan_sequencer dut (.*);
	amss_scan_checker chk (.*);

	always #1 clk = ~clk;

	initial begin
		#1000000;
		$display("tb failed");
		$finish;
	end

	// Receiver: random stall, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = 48;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic set_idling(input idle_mode_e mode);
		send_pct  = (mode == IDLE_SEND) ? 66 : (mode == IDLE_BOTH) ? 26 : 0;
		stall_pct = (mode == IDLE_RECV) ? 66 : (mode == IDLE_BOTH) ? 26 : 0;
	endtask

	task automatic offer(input logic act, input logic [15:0] word);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		rx_word  <= word;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stop offering, wait for every outstanding result, then let the clock run on.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (due_count == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx < REG_COUNT_DEV0)
			list_shadow[idx[1:0]] = data;
		else
			count_shadow[idx[1:0]] = data[4:0];
	endtask

	function automatic int live_frames(input int dev);
		return (count_shadow[dev] > 5'd16) ? 16 : int'(count_shadow[dev]);
	endfunction

	task automatic load_config(input cfg_style_e style);
		logic [63:0] lst;
		logic [4:0]  cnt;
		for (int d = 0; d < 4; d++) begin
			case ($urandom_range(3))
				0: lst = {16{4'($urandom)}};
				1: lst = $urandom_range(1) ? '1 : '0;
				default: lst = {$urandom, $urandom};
			endcase
			case (style)
				LIST_FULL:   cnt = 5'd16;
				LIST_SPARSE: cnt = 5'($urandom_range(1));
				LIST_OVER:   cnt = 5'($urandom_range(17, 31));
				LIST_EMPTY:  cnt = 5'd0;
				default:     cnt = 5'($urandom_range(16));
			endcase
			write_reg(REG_LIST_DEV0 + CFG_IDX_W'(d), lst);
			write_reg(REG_COUNT_DEV0 + CFG_IDX_W'(d), 64'(cnt));
		end
	endtask

	// One scan: start, then a response per frame of every live device.
	task automatic run_scan();
		int          n;
		logic [3:0]  ch;
		logic [11:0] smp;
		offer(ACT_START, 16'($urandom));
		items_sent++;
		for (int d = 0; d < 4; d++) begin
			n = live_frames(d);
			if (n == 0)
				continue;
			for (int f = 0; f < n + FLUSH_FRAMES; f++) begin
				if ($urandom_range(99) < 80)
					ch = list_shadow[d][4*$urandom_range(n-1) +: 4];
				else
					ch = 4'($urandom);
				case ($urandom_range(9))
					0: smp = 12'h000;
					1: smp = 12'hfff;
					default: smp = 12'($urandom);
				endcase
				offer(ACT_RESPONSE, {ch, smp});
				items_sent++;
				// Abandon the scan now and then with a restart.
				if ($urandom_range(199) == 0) begin
					offer(ACT_START, 16'($urandom));
					items_sent++;
					return;
				end
			end
		end
		// Stray responses after the scan; the block drops them.
		if ($urandom_range(99) < 15)
			repeat ($urandom_range(1, 2))
				offer(ACT_RESPONSE, 16'($urandom));
	endtask

	cfg_style_e phase_style [10] = '{LIST_FULL, LIST_RANDOM, LIST_SPARSE, LIST_RANDOM,
		LIST_OVER, LIST_RANDOM, LIST_EMPTY, LIST_RANDOM, LIST_FULL, LIST_RANDOM};

	initial begin
		int scans;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		action     = ACT_START;
		rx_word    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		out_stall  = 1'b0;
		hold_reqs  = 0;
		hold_seen  = 0;
		hold_left  = 0;
		items_sent = 0;
		for (int d = 0; d < 4; d++) begin
			list_shadow[d]  = '0;
			count_shadow[d] = '0;
		end
		set_idling(IDLE_NONE);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Nothing configured: start finds no device, responses are ignored.
		offer(ACT_START, 16'hffff);
		offer(ACT_RESPONSE, 16'hffff);
		offer(ACT_RESPONSE, 16'h0000);
		drain();

		write_reg(REG_LIST_DEV0 + 3'd0, 64'h0123_4567_89ab_cdef);
		write_reg(REG_COUNT_DEV0 + 3'd0, 64'd2);
		write_reg(REG_LIST_DEV0 + 3'd1, {16{4'h5}});
		write_reg(REG_COUNT_DEV0 + 3'd1, 64'd3);
		write_reg(REG_LIST_DEV0 + 3'd2, '1);
		write_reg(REG_COUNT_DEV0 + 3'd2, 64'd0);
		write_reg(REG_LIST_DEV0 + 3'd3, 64'hfedc_ba98_7654_3210);
		write_reg(REG_COUNT_DEV0 + 3'd3, 64'd31);

		offer(ACT_START, 16'h0000);
		offer(ACT_RESPONSE, 16'hf000);
		offer(ACT_RESPONSE, 16'hefff);
		offer(ACT_RESPONSE, 16'h0000);
		offer(ACT_RESPONSE, 16'hffff);
		// Device 1 has one channel listed three times.
		offer(ACT_RESPONSE, 16'h5abc);
		offer(ACT_RESPONSE, 16'h1234);
		offer(ACT_RESPONSE, 16'h5555);
		offer(ACT_RESPONSE, 16'h0000);
		offer(ACT_RESPONSE, 16'h5fff);
		// Device 2 skipped; device 3 count clamps to sixteen.
		offer(ACT_RESPONSE, 16'h0000);
		offer(ACT_RESPONSE, 16'hffff);
		// Restart mid-scan.
		offer(ACT_START, 16'h8001);
		offer(ACT_RESPONSE, 16'hf123);
		drain();
		// Shrink device 0 below its current frame: it must end at once.
		write_reg(REG_COUNT_DEV0 + 3'd0, 64'd0);
		offer(ACT_RESPONSE, 16'he001);
		offer(ACT_RESPONSE, 16'h5001);
		drain();

		for (int p = 0; p < 10; p++) begin
			load_config(phase_style[p]);
			set_idling(idle_mode_e'(p % 4));
			items_sent = 0;
			scans = 0;
			while (items_sent < 170) begin
				if (p == 0 && (scans == 1 || scans == 2))
					hold_reqs++;
				run_scan();
				scans++;
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
